// ===== src/ttr_pkg.sv =====
// Package for the direct-mapped transposition table with replacement.
// Holds the request, response and entry types and the register indexes.
// No dependencies.
package ttr_pkg;

   localparam int TAG_SHIFT    = 48;
   localparam int CSR_IDX_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_REPLACE_DEPTH = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REPLACE_AGE   = 8'd1;

   localparam logic [7:0]  RESET_REPLACE_DEPTH = 8'd4;
   localparam logic [7:0]  RESET_REPLACE_AGE   = 8'd2;
   localparam logic [15:0] EMPTY_TAG           = 16'd0;

   localparam logic MODE_PROBE = 1'b0;
   localparam logic MODE_STORE = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [63:0]        hash;
      logic [15:0]        best_move;
      logic signed [7:0]  search_depth;
      logic [7:0]         bound_kind;
      logic [7:0]         search_age;
      logic signed [15:0] score;
   } req_type;

   typedef struct packed {
      logic               found;
      logic               written;
      logic [15:0]        slot_tag;
      logic [15:0]        slot_move;
      logic signed [7:0]  slot_depth;
      logic [7:0]         slot_bound;
      logic [7:0]         slot_age;
      logic signed [15:0] slot_score;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        tag;
      logic [15:0]        move;
      logic signed [7:0]  depth;
      logic [7:0]         bound;
      logic [7:0]         age;
      logic signed [15:0] score;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

// ===== src/direct_mapped_tt_with_replacement_top.sv =====
// Top level of the direct-mapped transposition table with replacement.
// Instantiates ttr_ctrl and ttr_dpath; depends on ttr_pkg.
//
// A probe or store is taken when start is high and busy is low. The entry
// memory is read at that edge, and in the next cycle the replacement rule is
// evaluated and the slot written; busy stays high in the decide state, so a
// new transaction is not taken before this one is done. The response strobe
// rsp_valid is high for one cycle, registered from the decide state, and
// carries the slot contents as they were before the transaction.
// There is no backpressure on responses: the receiver must take each one when
// it is shown. After reset, busy stays high while a clearing pass empties
// every slot; configuration writes are taken at any time but must only be
// issued while the block is idle.
module direct_mapped_tt_with_replacement_top import ttr_pkg::*; #(
   parameter int INDEX_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_type                 req,
   output logic                    rsp_valid,
   output rsp_type                 rsp,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [7:0]              csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ttr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ttr_dpath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Block did not turn busy after taking a transaction.");

   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Responses came in consecutive cycles.");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp.found && rsp.written))
      else $error("A response reported both found and written.");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("No response two cycles after a transaction was taken.");

endmodule

// ===== src/ttr_ctrl.sv =====
// Controller state machine for the transposition table.
// Depends on ttr_pkg for the command and status types.
module ttr_ctrl import ttr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/ttr_dpath.sv =====
// Datapath for the transposition table: entry memory, replacement decision,
// configuration registers and response register. Depends on ttr_pkg.
module ttr_dpath import ttr_pkg::*; #(
   parameter int INDEX_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  req_type                 req,
   output logic                    rsp_valid,
   output rsp_type                 rsp,
   input  logic                    csr_valid,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [7:0]              csr_wdata
);

   localparam int SLOTS = 1 << INDEX_BITS;

   entry_type mem [SLOTS];

   logic [INDEX_BITS-1:0] clr_ff;
   logic [7:0]            replace_depth_ff;
   logic [7:0]            replace_age_ff;
   req_type               req_ff;
   entry_type             rd_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic [15:0]           new_tag;
   logic                  match;
   logic signed [9:0]     depth_gain;
   logic signed [9:0]     age_gain;
   logic                  replace;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_addr;
   entry_type             wr_data;
   rsp_type               rsp_in;

   assign status.clear_last = &clr_ff;

   assign new_tag    = req_ff.hash[TAG_SHIFT +: 16];
   assign match      = (rd_ff.tag == new_tag);
   assign depth_gain = 10'(req_ff.search_depth) - 10'(rd_ff.depth);
   assign age_gain   = $signed({2'b00, req_ff.search_age}) - $signed({2'b00, rd_ff.age});

   assign replace = (rd_ff.tag == EMPTY_TAG) ||
                    (match && (depth_gain > 10'sd0)) ||
                    (!match && (depth_gain >= $signed({2'b00, replace_depth_ff}))) ||
                    (age_gain >= $signed({2'b00, replace_age_ff}));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.decide && (req_ff.mode == MODE_STORE) && replace) begin
         wr_en         = 1'b1;
         wr_addr       = req_ff.hash[INDEX_BITS-1:0];
         wr_data.tag   = new_tag;
         wr_data.move  = req_ff.best_move;
         wr_data.depth = req_ff.search_depth;
         wr_data.bound = req_ff.bound_kind;
         wr_data.age   = req_ff.search_age;
         wr_data.score = req_ff.score;
      end
   end

   always_comb begin
      rsp_in.found      = (req_ff.mode == MODE_PROBE) && match;
      rsp_in.written    = (req_ff.mode == MODE_STORE) && replace;
      rsp_in.slot_tag   = rd_ff.tag;
      rsp_in.slot_move  = rd_ff.move;
      rsp_in.slot_depth = rd_ff.depth;
      rsp_in.slot_bound = rd_ff.bound;
      rsp_in.slot_age   = rd_ff.age;
      rsp_in.slot_score = rd_ff.score;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.accept) begin
         rd_ff <= mem[req.hash[INDEX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req;
      end
      if (cmd.decide) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff           <= '0;
         replace_depth_ff <= RESET_REPLACE_DEPTH;
         replace_age_ff   <= RESET_REPLACE_AGE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.decide;
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_REPLACE_DEPTH: begin
                  replace_depth_ff <= csr_wdata;
               end
               CSR_REPLACE_AGE: begin
                  replace_age_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
